// ----- rtl/rlpc_pkg.sv -----
package rlpc_pkg;

	// register indexes of the configuration port
	typedef enum logic [0:0] {
		CFG_OWN_ADDRESS     = 1'b0,
		CFG_INITIAL_PARTNER = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		ACT_FRAME     = 2'd0,
		ACT_REJECT_TO = 2'd1,
		ACT_LINK_TO   = 2'd2,
		ACT_POPPED    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MOTOR_NONE     = 2'd0,
		MOTOR_STARTUP  = 2'd1,
		MOTOR_SHUTDOWN = 2'd2
	} motor_cmd_t;

	typedef enum logic [1:0] {
		LINK_NONE    = 2'd0,
		LINK_RESTART = 2'd1,
		LINK_STOP    = 2'd2
	} link_cmd_t;

	localparam logic [7:0]  API_TX_STATUS    = 8'h89;
	localparam logic [7:0]  RX_OPT_BROADCAST = 8'h06;
	localparam logic [7:0]  HDR_PAIR_ACK     = 8'h02;
	localparam logic [7:0]  HDR_STATUS       = 8'h04;
	localparam logic [7:0]  PAY_ACK          = 8'h01;
	localparam logic [7:0]  PAY_NORMAL       = 8'h00;
	localparam logic [7:0]  PAY_POPPED       = 8'h01;
	localparam logic [7:0]  FRAME_API_TX     = 8'h01;
	localparam logic [7:0]  FRAME_ID         = 8'h52;
	localparam logic [7:0]  FRAME_OPTIONS    = 8'h00;
	localparam logic [7:0]  RESET_OWN_ADDR   = 8'h0C;
	localparam logic [15:0] RESET_PARTNER    = 16'h218D;

	localparam int CMD_POP_BIT    = 0;
	localparam int CMD_UNPAIR_BIT = 7;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  api_id;
		logic [15:0] source_addr;
		logic [7:0]  rx_opts;
		logic [7:0]  pair_target;
		logic [7:0]  command_bits;
	} item_t;

	typedef struct packed {
		logic        send_frame;
		logic [7:0]  frame_header;
		logic [7:0]  frame_payload;
		logic [15:0] dest_addr;
		logic [7:0]  frame_checksum;
		logic        motor_new_data;
		logic [1:0]  motor_cmd;
		logic        pop_request;
		logic        popper_shutdown;
		logic [1:0]  link_timer_cmd;
		logic        reject_timer_start;
		logic        paired;
	} result_t;

	typedef struct packed {
		logic        paired_mode;
		logic [15:0] partner_addr;
		logic [15:0] rejected_addr;
	} link_state_t;

	// 0xff minus low byte of the sum of reply bytes 3 to 9
	function automatic logic [7:0] frame_sum(input logic [15:0] dest,
			input logic [7:0] header, input logic [7:0] payload);
		logic [7:0] s;
		s = FRAME_API_TX + FRAME_ID + dest[15:8] + dest[7:0] + FRAME_OPTIONS
			+ header + payload;
		return ~s;
	endfunction

endpackage

// ----- rtl/rlpc_item_if.sv -----
interface rlpc_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  api_id;
	logic [15:0] source_addr;
	logic [7:0]  rx_opts;
	logic [7:0]  pair_target;
	logic [7:0]  command_bits;

	modport source (output valid, action, api_id, source_addr, rx_opts,
		pair_target, command_bits, input ready);
	modport sink (input valid, action, api_id, source_addr, rx_opts,
		pair_target, command_bits, output ready);
endinterface

// ----- rtl/rlpc_result_if.sv -----
interface rlpc_result_if;
	logic        valid;
	logic        ready;
	logic        send_frame;
	logic [7:0]  frame_header;
	logic [7:0]  frame_payload;
	logic [15:0] dest_addr;
	logic [7:0]  frame_checksum;
	logic        motor_new_data;
	logic [1:0]  motor_cmd;
	logic        pop_request;
	logic        popper_shutdown;
	logic [1:0]  link_timer_cmd;
	logic        reject_timer_start;
	logic        paired;

	modport source (output valid, send_frame, frame_header, frame_payload, dest_addr,
		frame_checksum, motor_new_data, motor_cmd, pop_request, popper_shutdown,
		link_timer_cmd, reject_timer_start, paired, input ready);
	modport sink (input valid, send_frame, frame_header, frame_payload, dest_addr,
		frame_checksum, motor_new_data, motor_cmd, pop_request, popper_shutdown,
		link_timer_cmd, reject_timer_start, paired, output ready);
endinterface

// ----- rtl/rlpc_decide.sv -----
module rlpc_decide (
	input  rlpc_pkg::item_t       item,
	input  logic [7:0]            own_addr,
	input  rlpc_pkg::link_state_t cur,
	output rlpc_pkg::result_t     res,
	output rlpc_pkg::link_state_t nxt
);

	logic       not_status;
	logic       bcast;
	logic [7:0] hdr;
	logic [7:0] pay;

	assign not_status = (item.api_id != rlpc_pkg::API_TX_STATUS);
	assign bcast      = (item.rx_opts == rlpc_pkg::RX_OPT_BROADCAST);

	always_comb begin
		res = '0;
		nxt = cur;
		hdr = rlpc_pkg::HDR_STATUS;
		pay = rlpc_pkg::PAY_NORMAL;
		if (item.action == rlpc_pkg::ACT_REJECT_TO) begin
			nxt.rejected_addr = '0;
		end else if (!cur.paired_mode) begin
			if (item.action == rlpc_pkg::ACT_FRAME && not_status && bcast
					&& item.pair_target == own_addr
					&& item.source_addr != cur.rejected_addr) begin
				hdr              = rlpc_pkg::HDR_PAIR_ACK;
				pay              = rlpc_pkg::PAY_ACK;
				nxt.partner_addr = item.source_addr;
				nxt.paired_mode  = 1'b1;
				res.send_frame   = 1'b1;
				res.motor_cmd    = rlpc_pkg::MOTOR_STARTUP;
				res.link_timer_cmd = rlpc_pkg::LINK_RESTART;
			end
		end else begin
			case (item.action)
				rlpc_pkg::ACT_FRAME: begin
					if (not_status && !bcast && item.source_addr == cur.partner_addr) begin
						res.send_frame     = 1'b1;
						res.motor_new_data = 1'b1;
						res.pop_request    = item.command_bits[rlpc_pkg::CMD_POP_BIT];
						res.link_timer_cmd = rlpc_pkg::LINK_RESTART;
						if (item.command_bits[rlpc_pkg::CMD_UNPAIR_BIT]) begin
							nxt.paired_mode     = 1'b0;
							res.link_timer_cmd  = rlpc_pkg::LINK_STOP;
							res.motor_cmd       = rlpc_pkg::MOTOR_SHUTDOWN;
							res.popper_shutdown = 1'b1;
						end
					end
				end
				rlpc_pkg::ACT_LINK_TO: begin
					nxt.paired_mode = 1'b0;
					res.motor_cmd   = rlpc_pkg::MOTOR_SHUTDOWN;
				end
				default: begin
					// balloon popped: final status, then reject this partner
					pay                    = rlpc_pkg::PAY_POPPED;
					res.send_frame         = 1'b1;
					nxt.paired_mode        = 1'b0;
					nxt.rejected_addr      = cur.partner_addr;
					res.motor_cmd          = rlpc_pkg::MOTOR_SHUTDOWN;
					res.reject_timer_start = 1'b1;
				end
			endcase
		end
		if (res.send_frame) begin
			res.frame_header   = hdr;
			res.frame_payload  = pay;
			res.dest_addr      = nxt.partner_addr;
			res.frame_checksum = rlpc_pkg::frame_sum(nxt.partner_addr, hdr, pay);
		end
		res.paired = nxt.paired_mode;
	end

endmodule

// ----- rtl/radio_link_pairing_controller_top.sv -----
// radio link pairing controller
//
// item channel: one event per request (frame received, reject timeout, link
// timeout, balloon popped) with the received frame's header fields
// reply channel: one request per event carrying the reply frame (header,
// payload, destination, checksum) and the command flags for motor, popper and
// timers, plus the mode after the event
// config port: cfg_we with cfg_index 0 writes own address, 1 writes the
// initial partner address and loads it as current partner
//
// the reply shows valid once the event moves from the input register into the
// reply register, so the reply handshake comes after the item handshake
// throughput is one event per cycle while replies are taken: an input
// register holds the event, the mode/partner decision and the byte-sum
// checksum are combinational, and the reply register takes the result while
// the next event is accepted; a stalled reply holds in the reply register;
// the input register then fills and item.ready drops until the reply is taken
// reset: unpaired, partner 0x218d, no rejected address, own address 0x0c,
// both stages empty
module radio_link_pairing_controller_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [15:0]           cfg_wdata,
	rlpc_item_if.sink             item,
	rlpc_result_if.source         reply
);

	// configuration and link state
	logic [7:0]            own_addr_q;
	rlpc_pkg::link_state_t state_q;

	// input stage
	logic                  valid_s1;
	rlpc_pkg::item_t       item_s1;

	// reply stage
	logic                  valid_q;
	rlpc_pkg::result_t     res_q;

	rlpc_pkg::item_t       item_in;
	rlpc_pkg::result_t     res_d;
	rlpc_pkg::link_state_t state_d;
	logic                  advance;

	assign item_in.action       = item.action;
	assign item_in.api_id       = item.api_id;
	assign item_in.source_addr  = item.source_addr;
	assign item_in.rx_opts      = item.rx_opts;
	assign item_in.pair_target  = item.pair_target;
	assign item_in.command_bits = item.command_bits;

	assign advance    = valid_s1 && (!valid_q || reply.ready);
	assign item.ready = !valid_s1 || advance;

	rlpc_decide u_decide (
		.item     (item_s1),
		.own_addr (own_addr_q),
		.cur      (state_q),
		.res      (res_d),
		.nxt      (state_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (reply.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// state moves per decided event; user writes config only when idle, unchecked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q            <= rlpc_pkg::RESET_OWN_ADDR;
			state_q.paired_mode   <= 1'b0;
			state_q.partner_addr  <= rlpc_pkg::RESET_PARTNER;
			state_q.rejected_addr <= '0;
		end else if (advance) begin
			state_q <= state_d;
		end else if (cfg_we) begin
			case (rlpc_pkg::cfg_index_t'(cfg_index))
				rlpc_pkg::CFG_OWN_ADDRESS: begin
					own_addr_q <= cfg_wdata[7:0];
				end
				rlpc_pkg::CFG_INITIAL_PARTNER: begin
					state_q.partner_addr <= cfg_wdata;
				end
				default: begin
					own_addr_q <= own_addr_q;
				end
			endcase
		end
	end

	assign reply.valid              = valid_q;
	assign reply.send_frame         = res_q.send_frame;
	assign reply.frame_header       = res_q.frame_header;
	assign reply.frame_payload      = res_q.frame_payload;
	assign reply.dest_addr          = res_q.dest_addr;
	assign reply.frame_checksum     = res_q.frame_checksum;
	assign reply.motor_new_data     = res_q.motor_new_data;
	assign reply.motor_cmd          = res_q.motor_cmd;
	assign reply.pop_request        = res_q.pop_request;
	assign reply.popper_shutdown    = res_q.popper_shutdown;
	assign reply.link_timer_cmd     = res_q.link_timer_cmd;
	assign reply.reject_timer_start = res_q.reject_timer_start;
	assign reply.paired             = res_q.paired;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	// cycles from item acceptance to the reply showing valid
	localparam int REPLY_LATENCY = 1;
	// watchdog, far above the slowest correct run
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [15:0] cfg_wdata;

	rlpc_item_if item_ch();
	rlpc_result_if reply_ch();

	radio_link_pairing_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.reply     (reply_ch)
	);

	always #5 clk = ~clk;

	// predictor copy of the link state and the two registers
	logic        link_paired;
	logic [15:0] link_partner;
	logic [15:0] link_rejected;
	logic [7:0]  own_addr_reg;
	logic [15:0] initial_partner_reg;

	// replies predicted for accepted requests, oldest first
	rlpc_pkg::result_t pending_replies[$];

	int error_count = 0;
	int cycle_count = 0;

	// sender burst control and receiver stall control
	bit sender_gaps = 1'b0;
	int burst_left = 0;
	bit reply_stalls = 1'b0;
	logic [31:0] stall_mask = 32'h1;
	int stall_phase = 0;

	// reply frame with destination and checksum filled from the current partner
	function automatic rlpc_pkg::result_t reply_frame(logic [7:0] hdr, logic [7:0] pay);
		rlpc_pkg::result_t r;
		int sum;
		r = '0;
		r.send_frame = 1'b1;
		r.frame_header = hdr;
		r.frame_payload = pay;
		r.dest_addr = link_partner;
		// bytes 3 to 9 of the outgoing frame
		sum = rlpc_pkg::FRAME_API_TX + rlpc_pkg::FRAME_ID + link_partner[15:8]
			+ link_partner[7:0] + rlpc_pkg::FRAME_OPTIONS + hdr + pay;
		r.frame_checksum = 8'hFF - sum[7:0];
		return r;
	endfunction

	// next reply for one accepted event, and the state after it
	function automatic rlpc_pkg::result_t predict_reply(rlpc_pkg::item_t ev);
		rlpc_pkg::result_t r;
		r = '0;
		if (ev.action == rlpc_pkg::ACT_REJECT_TO) begin
			// reject timer expiry clears the blocked address in any mode
			link_rejected = '0;
		end else if (!link_paired) begin
			// only a broadcast pair request for our address from an unblocked source
			if (ev.action == rlpc_pkg::ACT_FRAME && ev.api_id != rlpc_pkg::API_TX_STATUS
					&& ev.rx_opts == rlpc_pkg::RX_OPT_BROADCAST
					&& ev.pair_target == own_addr_reg
					&& ev.source_addr != link_rejected) begin
				link_partner = ev.source_addr;
				r = reply_frame(rlpc_pkg::HDR_PAIR_ACK, rlpc_pkg::PAY_ACK);
				r.motor_cmd = rlpc_pkg::MOTOR_STARTUP;
				r.link_timer_cmd = rlpc_pkg::LINK_RESTART;
				link_paired = 1'b1;
			end
		end else if (ev.action == rlpc_pkg::ACT_FRAME) begin
			// paired: unicast frames from the partner only
			if (ev.api_id != rlpc_pkg::API_TX_STATUS
					&& ev.rx_opts != rlpc_pkg::RX_OPT_BROADCAST
					&& ev.source_addr == link_partner) begin
				r = reply_frame(rlpc_pkg::HDR_STATUS, rlpc_pkg::PAY_NORMAL);
				r.motor_new_data = 1'b1;
				r.pop_request = ev.command_bits[rlpc_pkg::CMD_POP_BIT];
				r.link_timer_cmd = rlpc_pkg::LINK_RESTART;
				if (ev.command_bits[rlpc_pkg::CMD_UNPAIR_BIT]) begin
					// stop wins over the restart when the unpair bit is set
					link_paired = 1'b0;
					r.link_timer_cmd = rlpc_pkg::LINK_STOP;
					r.motor_cmd = rlpc_pkg::MOTOR_SHUTDOWN;
					r.popper_shutdown = 1'b1;
				end
			end
		end else if (ev.action == rlpc_pkg::ACT_LINK_TO) begin
			link_paired = 1'b0;
			r.motor_cmd = rlpc_pkg::MOTOR_SHUTDOWN;
		end else begin
			// balloon popped: tell the partner, then block it for a while
			r = reply_frame(rlpc_pkg::HDR_STATUS, rlpc_pkg::PAY_POPPED);
			link_paired = 1'b0;
			r.motor_cmd = rlpc_pkg::MOTOR_SHUTDOWN;
			link_rejected = link_partner;
			r.reject_timer_start = 1'b1;
		end
		r.paired = link_paired;
		return r;
	endfunction

	function automatic string describe(rlpc_pkg::result_t r);
		return $sformatf({"send=%0b hdr=%02h pay=%02h dest=%04h chk=%02h mnew=%0b",
			" mcmd=%0d pop=%0b pshut=%0b link=%0d rej=%0b paired=%0b"},
			r.send_frame, r.frame_header, r.frame_payload, r.dest_addr,
			r.frame_checksum, r.motor_new_data, r.motor_cmd, r.pop_request,
			r.popper_shutdown, r.link_timer_cmd, r.reject_timer_start, r.paired);
	endfunction

	function automatic void note_failure(string msg);
		error_count++;
		if (error_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	function automatic rlpc_pkg::item_t event_item(rlpc_pkg::action_t a, logic [7:0] api,
			logic [15:0] src, logic [7:0] rx, logic [7:0] tgt, logic [7:0] cmd);
		rlpc_pkg::item_t ev;
		ev.action = a;
		ev.api_id = api;
		ev.source_addr = src;
		ev.rx_opts = rx;
		ev.pair_target = tgt;
		ev.command_bits = cmd;
		return ev;
	endfunction

	// any bit pattern at all, including unknown-to-the-block api ids
	function automatic rlpc_pkg::item_t noise_event();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[$bits(rlpc_pkg::item_t)-1:0];
	endfunction

	// random api id that is not a transmit status
	function automatic logic [7:0] data_api();
		logic [7:0] api;
		api = 8'($urandom_range(0, 255));
		if (api == rlpc_pkg::API_TX_STATUS)
			api[0] = ~api[0];
		return api;
	endfunction

	// timer or pop event with random leftovers in the unused fields
	function automatic rlpc_pkg::item_t timer_event(rlpc_pkg::action_t a);
		rlpc_pkg::item_t ev;
		ev = noise_event();
		ev.action = a;
		return ev;
	endfunction

	function automatic rlpc_pkg::item_t pair_request(logic [15:0] src);
		return event_item(rlpc_pkg::ACT_FRAME, data_api(), src, rlpc_pkg::RX_OPT_BROADCAST,
			own_addr_reg, 8'($urandom_range(0, 255)));
	endfunction

	function automatic rlpc_pkg::item_t partner_frame(logic [7:0] cmd);
		logic [7:0] rx;
		rx = 8'($urandom_range(0, 255));
		if (rx == rlpc_pkg::RX_OPT_BROADCAST)
			rx = rx ^ 8'h01;
		return event_item(rlpc_pkg::ACT_FRAME, data_api(), link_partner, rx,
			8'($urandom_range(0, 255)), cmd);
	endfunction

	task automatic drive_fields(rlpc_pkg::item_t ev);
		item_ch.action <= ev.action;
		item_ch.api_id <= ev.api_id;
		item_ch.source_addr <= ev.source_addr;
		item_ch.rx_opts <= ev.rx_opts;
		item_ch.pair_target <= ev.pair_target;
		item_ch.command_bits <= ev.command_bits;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so the caller either sends again or drains
	task automatic send_event(rlpc_pkg::item_t ev);
		int gap;
		if (sender_gaps && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			item_ch.valid <= 1'b0;
			drive_fields(noise_event());
			repeat (gap) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		item_ch.valid <= 1'b1;
		drive_fields(ev);
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		pending_replies.push_back(predict_reply(ev));
		@(negedge clk);
	endtask

	// stop sending and wait for every pending reply
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_replies.size() != 0)
			@(negedge clk);
	endtask

	// both registers, written back to back while the block is idle
	task automatic write_config(logic [7:0] own, logic [15:0] partner);
		wait_drained();
		repeat (REPLY_LATENCY) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= rlpc_pkg::CFG_OWN_ADDRESS;
		// upper byte is junk, own address takes the low byte only
		cfg_wdata <= {8'($urandom_range(0, 255)), own};
		@(negedge clk);
		cfg_index <= rlpc_pkg::CFG_INITIAL_PARTNER;
		cfg_wdata <= partner;
		@(negedge clk);
		cfg_we <= 1'b0;
		own_addr_reg = own;
		initial_partner_reg = partner;
		// the partner write also replaces the current partner
		link_partner = partner;
		@(negedge clk);
	endtask

	// mostly well-formed pairing sessions with random content, some noise
	task automatic run_sessions(int n_events);
		rlpc_pkg::item_t ev;
		int pick;
		repeat (n_events) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				ev = noise_event();
			end else if (!link_paired) begin
				if (pick < 18)
					ev = pair_request(link_rejected);
				else if (pick < 24)
					ev = timer_event(rlpc_pkg::ACT_REJECT_TO);
				else if (pick < 28)
					ev = timer_event($urandom_range(0, 1) ? rlpc_pkg::ACT_LINK_TO
						: rlpc_pkg::ACT_POPPED);
				else if (pick < 32)
					ev = pair_request($urandom_range(0, 1) ? 16'h0000 : 16'hFFFF);
				else
					ev = pair_request(16'($urandom_range(0, 65535)));
			end else begin
				if (pick < 14) begin
					ev = timer_event(rlpc_pkg::ACT_LINK_TO);
				end else if (pick < 19) begin
					ev = timer_event(rlpc_pkg::ACT_POPPED);
				end else if (pick < 25) begin
					ev = timer_event(rlpc_pkg::ACT_REJECT_TO);
				end else if (pick < 33) begin
					// near misses: broadcast, transmit status or a stranger
					ev = partner_frame(8'($urandom_range(0, 255)));
					case ($urandom_range(0, 2))
						0: ev.rx_opts = rlpc_pkg::RX_OPT_BROADCAST;
						1: ev.api_id = rlpc_pkg::API_TX_STATUS;
						default: ev.source_addr = ev.source_addr
							^ 16'($urandom_range(1, 65535));
					endcase
				end else begin
					ev = partner_frame({($urandom_range(0, 9) == 0), 7'($urandom_range(0, 127))});
				end
			end
			send_event(ev);
			// now and then hold off until the reply side has caught up
			if ($urandom_range(0, 99) == 0)
				wait_drained();
		end
	endtask

	// reset defaults, every event type and each corner of the pairing rules
	task automatic test_directed_cases();
		sender_gaps = 1'b0;
		reply_stalls = 1'b0;
		// unpaired: timers, pop and wrong frames do nothing
		send_event(event_item(rlpc_pkg::ACT_LINK_TO, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		send_event(event_item(rlpc_pkg::ACT_POPPED, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
		send_event(event_item(rlpc_pkg::ACT_REJECT_TO, 8'h81, 16'h1111, 8'h06, 8'h0C, 8'h81));
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'h1111, 8'h00,
			rlpc_pkg::RESET_OWN_ADDR, 8'h00));
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'h1111,
			rlpc_pkg::RX_OPT_BROADCAST, 8'h0D, 8'h00));
		send_event(event_item(rlpc_pkg::ACT_FRAME, rlpc_pkg::API_TX_STATUS, 16'h1111,
			rlpc_pkg::RX_OPT_BROADCAST, rlpc_pkg::RESET_OWN_ADDR, 8'h00));
		// source equal to the rejected address, which is zero after reset
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'h0000,
			rlpc_pkg::RX_OPT_BROADCAST, rlpc_pkg::RESET_OWN_ADDR, 8'h00));
		// good request, pairs with the top address
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'hFF, 16'hFFFF,
			rlpc_pkg::RX_OPT_BROADCAST, rlpc_pkg::RESET_OWN_ADDR, 8'hFF));
		// paired: broadcast, stranger and transmit status are ignored
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'hFFFF,
			rlpc_pkg::RX_OPT_BROADCAST, 8'h00, 8'h00));
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'hFFFE, 8'h00, 8'h00, 8'h00));
		send_event(event_item(rlpc_pkg::ACT_FRAME, rlpc_pkg::API_TX_STATUS, 16'hFFFF,
			8'h00, 8'h00, 8'h00));
		// partner status frames: plain, pop, other bits only
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h00, 16'hFFFF, 8'hFF, 8'h00, 8'h00));
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'hFFFF, 8'h00, 8'hFF, 8'h01));
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'hFFFF, 8'h01, 8'h55, 8'h7E));
		// reject timeout while paired keeps the pairing
		send_event(event_item(rlpc_pkg::ACT_REJECT_TO, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
		// pop together with unpair
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'hFFFF, 8'h00, 8'h00, 8'h81));
		// pair, pop the balloon, then the popped partner is blocked
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'h1234,
			rlpc_pkg::RX_OPT_BROADCAST, rlpc_pkg::RESET_OWN_ADDR, 8'h00));
		send_event(event_item(rlpc_pkg::ACT_POPPED, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'h1234,
			rlpc_pkg::RX_OPT_BROADCAST, rlpc_pkg::RESET_OWN_ADDR, 8'h00));
		// block lifted by the reject timer
		send_event(event_item(rlpc_pkg::ACT_REJECT_TO, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'h1234,
			rlpc_pkg::RX_OPT_BROADCAST, rlpc_pkg::RESET_OWN_ADDR, 8'h00));
		send_event(event_item(rlpc_pkg::ACT_LINK_TO, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
		// pair again and leave by unpair alone
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'h00FF,
			rlpc_pkg::RX_OPT_BROADCAST, rlpc_pkg::RESET_OWN_ADDR, 8'h00));
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'h00FF, 8'h00, 8'h00, 8'h80));
		// unicast from the old partner after unpairing is ignored
		send_event(event_item(rlpc_pkg::ACT_FRAME, 8'h81, 16'h00FF, 8'h00, 8'h00, 8'hFF));
		wait_drained();
	endtask

	// register extremes and a random setting, each with a short session run
	task automatic test_config_settings();
		sender_gaps = 1'b1;
		reply_stalls = 1'b1;
		write_config(8'h00, 16'h0000);
		run_sessions(90);
		write_config(8'hFF, 16'hFFFF);
		run_sessions(90);
		write_config(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
		run_sessions(90);
		// back to the reset values for the long run
		write_config(rlpc_pkg::RESET_OWN_ADDR, rlpc_pkg::RESET_PARTNER);
		run_sessions(90);
	endtask

	// long run with sender bursts and receiver stalls
	task automatic test_random_sessions();
		sender_gaps = 1'b1;
		reply_stalls = 1'b1;
		run_sessions(1100);
	endtask

	// full rate both sides, then full rate into a stalling receiver
	task automatic test_full_rate();
		sender_gaps = 1'b0;
		reply_stalls = 1'b0;
		run_sessions(150);
		reply_stalls = 1'b1;
		run_sessions(100);
	endtask

	// receiver: ready follows a rotating mask that the phase counter redraws;
	// about one mask in four is all ones for a stall-free stretch
	always @(negedge clk) begin
		if (reply_stalls) begin
			reply_ch.ready <= stall_mask[0];
			stall_mask = {stall_mask[0], stall_mask[31:1]};
			stall_phase++;
			if (stall_phase == 40) begin
				stall_phase = 0;
				stall_mask = ($urandom_range(0, 3) == 0) ? '1 : ($urandom() | 32'h1);
			end
		end else begin
			reply_ch.ready <= 1'b1;
		end
	end

	// reply checker: every accepted reply against the oldest prediction
	always @(posedge clk) begin
		rlpc_pkg::result_t got;
		rlpc_pkg::result_t want;
		if (arst_n && reply_ch.valid && reply_ch.ready) begin
			got = {reply_ch.send_frame, reply_ch.frame_header, reply_ch.frame_payload,
				reply_ch.dest_addr, reply_ch.frame_checksum, reply_ch.motor_new_data,
				reply_ch.motor_cmd, reply_ch.pop_request, reply_ch.popper_shutdown,
				reply_ch.link_timer_cmd, reply_ch.reject_timer_start, reply_ch.paired};
			if (pending_replies.size() == 0) begin
				note_failure({"reply with nothing pending: ", describe(got)});
			end else begin
				want = pending_replies.pop_front();
				if (got !== want)
					note_failure({"expected ", describe(want), " got ", describe(got)});
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** radio_link_pairing_controller_top: FAILED **");
			$finish;
		end
	end

	initial begin
		// every input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rlpc_pkg::CFG_OWN_ADDRESS;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.action = rlpc_pkg::ACT_FRAME;
		item_ch.api_id = '0;
		item_ch.source_addr = '0;
		item_ch.rx_opts = '0;
		item_ch.pair_target = '0;
		item_ch.command_bits = '0;
		reply_ch.ready = 1'b0;

		// predictor state after reset
		own_addr_reg = rlpc_pkg::RESET_OWN_ADDR;
		initial_partner_reg = rlpc_pkg::RESET_PARTNER;
		link_partner = rlpc_pkg::RESET_PARTNER;
		link_paired = 1'b0;
		link_rejected = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_config_settings();
		test_random_sessions();
		test_full_rate();

		// drain, then give the pipeline time to show any stray reply
		wait_drained();
		repeat (REPLY_LATENCY + 8) @(posedge clk);
		if (error_count == 0 && pending_replies.size() == 0) begin
			$display("** radio_link_pairing_controller_top: PASSED **");
		end else begin
			$display("** radio_link_pairing_controller_top: FAILED **");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/rlpc_pkg.sv
rtl/rlpc_item_if.sv
rtl/rlpc_result_if.sv
rtl/rlpc_decide.sv
rtl/radio_link_pairing_controller_top.sv
tb/tb_top.sv
